@@ rtl/bpc_pkg.sv @@
`default_nettype none

package bpc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_LONG_HOLD    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_HOME_HOLD    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_REPEAT_DELAY = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_REPEAT_PER   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_HIGHLIGHT    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_REPEAT_EN    = 3'd5;

  localparam logic [15:0] LONG_HOLD_RST    = 16'd600;
  localparam logic [15:0] HOME_HOLD_RST    = 16'd1500;
  localparam logic [15:0] REPEAT_DELAY_RST = 16'd400;
  localparam logic [15:0] REPEAT_PER_RST   = 16'd150;
  localparam logic [15:0] HIGHLIGHT_RST    = 16'd200;

  // Item opcodes.
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_INJECT = 2'd1;
  localparam logic [1:0] OP_FETCH  = 2'd2;

  // Action codes.
  localparam logic [3:0] ACT_NONE     = 4'd0;
  localparam logic [3:0] ACT_LEFT     = 4'd1;
  localparam logic [3:0] ACT_RIGHT    = 4'd2;
  localparam logic [3:0] ACT_PREV     = 4'd3;
  localparam logic [3:0] ACT_NEXT     = 4'd4;
  localparam logic [3:0] ACT_SEEK_BWD = 4'd5;
  localparam logic [3:0] ACT_SEEK_FWD = 4'd6;
  localparam logic [3:0] ACT_SELECT   = 4'd7;
  localparam logic [3:0] ACT_BACK     = 4'd8;
  localparam logic [3:0] ACT_HOME     = 4'd9;

  // Button numbers.
  localparam logic [1:0] BTN_LEFT   = 2'd0;
  localparam logic [1:0] BTN_MIDDLE = 2'd1;
  localparam logic [1:0] BTN_RIGHT  = 2'd2;
  localparam logic [1:0] BTN_NONE   = 2'd3;

  // Bit positions in the sent flags.
  localparam int unsigned FLAG_LONG = 0;
  localparam int unsigned FLAG_HOME = 1;
  localparam int unsigned FLAG_SIDE = 2;
  localparam int unsigned FLAG_REP  = 3;

  typedef struct packed {
    logic [15:0] long_hold_ms;
    logic [15:0] home_hold_ms;
    logic [15:0] rpt_delay;
    logic [15:0] repeat_period_ms;
    logic [15:0] glow_len;
    logic        repeat_enabled;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  pressed_bits;
    logic [31:0] now_ms;
    logic [3:0]  action_code;
  } item_t;

  typedef struct packed {
    logic [3:0]  fetched_action;
    logic [3:0]  pending_action;
    logic [1:0]  highlight_button;
    logic [31:0] highlight_deadline;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/bpc_if.sv @@
`default_nettype none

interface bpc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [2:0]  pressed_bits;
  logic [31:0] now_ms;
  logic [3:0]  action_code;

  modport source (output valid, output opcode, output pressed_bits, output now_ms,
                  output action_code, input ready);
  modport sink (input valid, input opcode, input pressed_bits, input now_ms,
                input action_code, output ready);
endinterface

interface bpc_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  fetched_action;
  logic [3:0]  pending_action;
  logic [1:0]  highlight_button;
  logic [31:0] highlight_deadline;

  modport source (output valid, output fetched_action, output pending_action,
                  output highlight_button, output highlight_deadline, input ready);
  modport sink (input valid, input fetched_action, input pending_action,
                input highlight_button, input highlight_deadline, output ready);
endinterface

`default_nettype wire

@@ rtl/bpc_cfg.sv @@
`default_nettype none

module bpc_cfg (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [bpc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [bpc_pkg::CfgDataW-1:0] cfg_wdata_i,
  output bpc_pkg::cfg_t                 cfg_o
);
  import bpc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LONG_HOLD:    cfg_d.long_hold_ms     = cfg_wdata_i;
        CFG_HOME_HOLD:    cfg_d.home_hold_ms     = cfg_wdata_i;
        CFG_REPEAT_DELAY: cfg_d.rpt_delay        = cfg_wdata_i;
        CFG_REPEAT_PER:   cfg_d.repeat_period_ms = cfg_wdata_i;
        CFG_HIGHLIGHT:    cfg_d.glow_len         = cfg_wdata_i;
        CFG_REPEAT_EN:    cfg_d.repeat_enabled   = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_hold_ms     <= LONG_HOLD_RST;
      cfg_q.home_hold_ms     <= HOME_HOLD_RST;
      cfg_q.rpt_delay        <= REPEAT_DELAY_RST;
      cfg_q.repeat_period_ms <= REPEAT_PER_RST;
      cfg_q.glow_len         <= HIGHLIGHT_RST;
      cfg_q.repeat_enabled   <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/bpc_core.sv @@
`default_nettype none

module bpc_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire bpc_pkg::cfg_t  cfg_i,
  input  wire logic           step_i,
  input  wire bpc_pkg::item_t item_i,
  output bpc_pkg::result_t    result_o
);
  import bpc_pkg::*;

  logic [3:0]  slot_q, slot_d;
  logic [1:0]  held_q, held_d;
  logic [1:0]  lit_btn_q, lit_btn_d;
  logic [31:0] lit_until_q, lit_until_d;
  logic        down_q, down_d;
  logic [3:0]  flags_q, flags_d;
  logic [31:0] press_q, press_d;
  logic [31:0] due_q, due_d;

  logic [1:0]  zone;
  logic [31:0] elapsed;
  logic [31:0] due_gap;
  logic        long_hit, home_hit;
  logic [3:0]  side_tap;
  logic [3:0]  side_long;
  logic        post_en, light_en;
  logic [3:0]  post_act;
  logic [1:0]  light_btn;
  logic [3:0]  fetched;

  always_comb begin
    if (item_i.pressed_bits[0]) begin
      zone = BTN_LEFT;
    end else if (item_i.pressed_bits[1]) begin
      zone = BTN_MIDDLE;
    end else if (item_i.pressed_bits[2]) begin
      zone = BTN_RIGHT;
    end else begin
      zone = BTN_NONE;
    end
  end

  assign elapsed   = item_i.now_ms - press_q;
  assign due_gap   = item_i.now_ms - due_q;
  assign long_hit  = elapsed >= {16'd0, cfg_i.long_hold_ms};
  assign home_hit  = elapsed >= {16'd0, cfg_i.home_hold_ms};
  assign side_tap  = (held_q == BTN_LEFT) ? ACT_LEFT : ACT_RIGHT;
  assign side_long = (held_q == BTN_LEFT) ? ACT_PREV : ACT_NEXT;

  always_comb begin
    held_d    = held_q;
    down_d    = down_q;
    flags_d   = flags_q;
    press_d   = press_q;
    due_d     = due_q;
    post_en   = 1'b0;
    light_en  = 1'b0;
    post_act  = ACT_NONE;
    light_btn = BTN_NONE;
    fetched   = ACT_NONE;

    unique case (item_i.opcode)
      OP_SAMPLE: begin
        if (zone == BTN_NONE) begin
          // Release: classify the press that just ended.
          if (down_q) begin
            if (held_q == BTN_MIDDLE) begin
              post_en   = 1'b1;
              light_btn = BTN_MIDDLE;
              if (flags_q[FLAG_HOME] || home_hit) begin
                post_act = ACT_HOME;
              end else if (flags_q[FLAG_LONG] || long_hit) begin
                post_act = ACT_BACK;
              end else begin
                post_act = ACT_SELECT;
              end
            end else if (!flags_q[FLAG_SIDE] && !flags_q[FLAG_REP]) begin
              post_en   = 1'b1;
              post_act  = side_tap;
              light_btn = held_q;
            end
          end
          down_d  = 1'b0;
          flags_d = '0;
          held_d  = BTN_NONE;
        end else if (!down_q) begin
          down_d    = 1'b1;
          held_d    = zone;
          press_d   = item_i.now_ms;
          due_d     = item_i.now_ms + {16'd0, cfg_i.rpt_delay};
          flags_d   = '0;
          light_en  = 1'b1;
          light_btn = zone;
        end else if (zone == held_q) begin
          if (held_q == BTN_MIDDLE) begin
            if (!flags_q[FLAG_HOME] && home_hit) begin
              flags_d[FLAG_HOME] = 1'b1;
            end else if (!flags_q[FLAG_LONG] && long_hit) begin
              flags_d[FLAG_LONG] = 1'b1;
            end
          end else if (!cfg_i.repeat_enabled && !flags_q[FLAG_SIDE] && long_hit) begin
            flags_d[FLAG_SIDE] = 1'b1;
            post_en   = 1'b1;
            post_act  = side_long;
            light_btn = held_q;
          end else if (cfg_i.repeat_enabled && !flags_q[FLAG_SIDE] && !due_gap[31]) begin
            // Repeat is due once now has reached the due time, modulo 2^32.
            flags_d[FLAG_REP] = 1'b1;
            post_en   = 1'b1;
            post_act  = side_tap;
            light_btn = held_q;
            due_d     = item_i.now_ms + {16'd0, cfg_i.repeat_period_ms};
          end
        end
      end
      OP_INJECT: begin
        post_en  = 1'b1;
        post_act = item_i.action_code;
        case (item_i.action_code) inside
          ACT_LEFT, ACT_PREV, ACT_SEEK_BWD:  light_btn = BTN_LEFT;
          ACT_RIGHT, ACT_NEXT, ACT_SEEK_FWD: light_btn = BTN_RIGHT;
          default:                           light_btn = BTN_MIDDLE;
        endcase
      end
      OP_FETCH: begin
        fetched = slot_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    slot_d      = slot_q;
    lit_btn_d   = lit_btn_q;
    lit_until_d = lit_until_q;
    if (item_i.opcode == OP_FETCH) begin
      slot_d = ACT_NONE;
    end
    if (post_en && slot_q == ACT_NONE) begin
      slot_d = post_act;
    end
    if (post_en || light_en) begin
      lit_btn_d   = light_btn;
      lit_until_d = item_i.now_ms + {16'd0, cfg_i.glow_len};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= ACT_NONE;
      held_q      <= BTN_NONE;
      lit_btn_q   <= BTN_NONE;
      lit_until_q <= '0;
      down_q      <= 1'b0;
      flags_q     <= '0;
      press_q     <= '0;
      due_q       <= '0;
    end else if (step_i) begin
      slot_q      <= slot_d;
      held_q      <= held_d;
      lit_btn_q   <= lit_btn_d;
      lit_until_q <= lit_until_d;
      down_q      <= down_d;
      flags_q     <= flags_d;
      press_q     <= press_d;
      due_q       <= due_d;
    end
  end

  assign result_o = '{fetched_action:     fetched,
                      pending_action:     slot_d,
                      highlight_button:   lit_btn_d,
                      highlight_deadline: lit_until_d};

endmodule

`default_nettype wire

@@ rtl/button_press_classifier.sv @@
`default_nettype none

// Pipeline: an accepted item fills the input register; its result fills the result register
// when the item steps, which waits while a result is untaken. Throughput: one item per cycle
// while results are taken; the state update is a single compare-and-add step.
// Reset: asynchronous, active low; clears the action slot, the press tracking and the
// highlight, and loads the configuration registers with their default values.

module button_press_classifier (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [bpc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [bpc_pkg::CfgDataW-1:0] cfg_wdata_i,
  bpc_in_if.sink                            in_ch,
  bpc_out_if.source                         out_ch
);
  import bpc_pkg::*;

  cfg_t    cfg;
  item_t   in_q;
  logic    in_vld_q;
  result_t res;
  result_t out_q;
  logic    out_vld_q;
  logic    step;

  // The stored item moves on when the result register is empty or being drained.
  assign step         = in_vld_q && (!out_vld_q || out_ch.ready);
  assign in_ch.ready  = !in_vld_q || step;

  bpc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bpc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (step),
    .item_i   (in_q),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_vld_q <= in_ch.valid;
      end
      if (step) begin
        out_vld_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      in_q.opcode       <= in_ch.opcode;
      in_q.pressed_bits <= in_ch.pressed_bits;
      in_q.now_ms       <= in_ch.now_ms;
      in_q.action_code  <= in_ch.action_code;
    end
    if (step) begin
      out_q <= res;
    end
  end

  assign out_ch.valid              = out_vld_q;
  assign out_ch.fetched_action     = out_q.fetched_action;
  assign out_ch.pending_action     = out_q.pending_action;
  assign out_ch.highlight_button   = out_q.highlight_button;
  assign out_ch.highlight_deadline = out_q.highlight_deadline;

endmodule

`default_nettype wire

@@ rtl/bpc_checker.sv @@
`default_nettype none

module bpc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [3:0]  fetched_action_i,
  input wire logic [3:0]  pending_action_i,
  input wire logic [1:0]  highlight_button_i,
  input wire logic [31:0] highlight_deadline_i
);
  import bpc_pkg::*;

  // A waiting result item keeps its pending action and deadline until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(pending_action_i)
      && $stable(highlight_deadline_i))
    else $error("stalled result item changed");

  // An accepted item must be followed by a valid result on the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> ##2 out_valid_i)
    else $error("accepted item produced no result");

  // A fetch that drains an action leaves the slot empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && fetched_action_i != ACT_NONE |-> pending_action_i == ACT_NONE)
    else $error("slot not cleared by fetch");

  // Until a button is first lit, the deadline keeps its reset value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && highlight_button_i == BTN_NONE |-> highlight_deadline_i == '0)
    else $error("deadline set without a highlight");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_ch.valid),
  .in_ready_i           (in_ch.ready),
  .out_valid_i          (out_ch.valid),
  .out_ready_i          (out_ch.ready),
  .fetched_action_i     (out_ch.fetched_action),
  .pending_action_i     (out_ch.pending_action),
  .highlight_button_i   (out_ch.highlight_button),
  .highlight_deadline_i (out_ch.highlight_deadline)
);

`default_nettype wire
